[rtl/bwds_pkg.sv]
// Shared types, constants and register codes for the burn-wire deploy sequencer.
`default_nettype none

package bwds_pkg;

   // Field and bus widths.
   localparam int TICKS_W      = 24;
   localparam int TIMER_W      = 25;
   localparam int TRIES_W      = 8;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 24;
   localparam int REQ_TDATA_W  = 8;
   localparam int RSP_TDATA_W  = 16;
   localparam int RSP_FIELDS_W = 5 + TRIES_W;

   // Fixed durations used when the block is not in real-time mode.
   localparam logic [TICKS_W-1:0] DEBUG_BURN_TICKS    = 24'd600;
   localparam logic [TICKS_W-1:0] DEBUG_REST_TICKS    = 24'd400;
   localparam logic [TICKS_W-1:0] DEBUG_RECHECK_TICKS = 24'd200;

   // Register reset values.
   localparam logic [TICKS_W-1:0] RESET_BURN_TICKS    = 24'd600;
   localparam logic [TICKS_W-1:0] RESET_REST_TICKS    = 24'd400;
   localparam logic [TICKS_W-1:0] RESET_RECHECK_TICKS = 24'd200;
   localparam logic [TRIES_W-1:0] RESET_MAX_TRIES     = 8'd3;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REALTIME_MODE = 3'd0,
      CSR_BURN_TICKS    = 3'd1,
      CSR_REST_TICKS    = 3'd2,
      CSR_RECHECK_TICKS = 3'd3,
      CSR_MAX_TRIES     = 3'd4
   } csr_index_type;

   // Input item kinds carried on tuser.
   typedef enum logic {
      OP_TICK  = 1'b0,
      OP_START = 1'b1
   } op_type;

   // Sequencer phases, one-hot.
   typedef enum logic [5:0] {
      PH_IDLE    = 6'b000001,
      PH_BURN1   = 6'b000010,
      PH_REST1   = 6'b000100,
      PH_BURN2   = 6'b001000,
      PH_REST2   = 6'b010000,
      PH_RECHECK = 6'b100000
   } phase_type;

   // Configuration as seen by the step logic.
   typedef struct packed {
      logic               realtime_mode;
      logic [TICKS_W-1:0] burn_ticks;
      logic [TICKS_W-1:0] rest_ticks;
      logic [TICKS_W-1:0] recheck_ticks;
      logic [TRIES_W-1:0] max_tries;
   } cfg_type;

   // Sequencer state.
   typedef struct packed {
      phase_type          phase;
      logic [TIMER_W-1:0] timer;
      logic [TRIES_W-1:0] attempts;
      logic               last_ok;
   } seq_state_type;

endpackage

`default_nettype wire

[rtl/burn_wire_deploy_sequencer.sv]
// Top level of the burn-wire deploy sequencer: input register, state, result register.
`default_nettype none

// Burn-wire antenna deploy sequencer. Each input transaction is a tick or a
// start request and produces exactly one result transaction showing the
// switch states, busy, run-finished flag (tlast), last outcome and attempt
// count after that item. Sustained rate is one transaction per clock while
// rsp_tready stays high; an item waits in the input register and its result
// is loaded into the result register once that register is free or draining,
// so a stalled result holds the next item in the input register. The rate
// is set by the single-pass step logic (one 25-bit timer increment and
// compare) between these two registers. Configuration writes are accepted
// every cycle and must only be issued while no transaction is in flight; a
// write during a run takes effect on the next item.
module burn_wire_deploy_sequencer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Input transactions.
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // tdata: [0] ant_sense, [1] already_deployed, [7:2] zero.
   input  wire logic [bwds_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser: [0] op.
   input  wire logic                             req_tuser,
   // Result transactions.
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // tdata: [0] common_switch_on, [1] element1_on, [2] element2_on,
   //        [3] busy_res, [4] deployed_ok, [12:5] tries_used, [15:13] zero.
   output logic [bwds_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // tlast: finished.
   output logic                                  rsp_tlast,
   // Configuration writes.
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [bwds_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bwds_pkg::CSR_DATA_W-1:0]  csr_data
);

   bwds_pkg::cfg_type       cfg;
   bwds_pkg::seq_state_type state_ff;
   bwds_pkg::seq_state_type state_in;
   logic                    ended;

   logic in_valid_ff;
   logic in_valid_in;
   logic in_op_ff;
   logic in_sense_ff;
   logic in_skip_ff;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic rsp_last_ff;
   logic [bwds_pkg::RSP_FIELDS_W-1:0] rsp_data_ff;
   logic [bwds_pkg::RSP_FIELDS_W-1:0] rsp_data_in;
   logic req_accept;
   logic fire;

   bwds_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bwds_step u_step (
      .cfg   (cfg),
      .cur   (state_ff),
      .op    (in_op_ff),
      .sense (in_sense_ff),
      .skip  (in_skip_ff),
      .nxt   (state_in),
      .ended (ended)
   );

   // Handshake: the held item moves on when the result register is free or drains.
   assign fire         = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || fire;
   assign req_accept   = req_tvalid && req_tready;
   assign in_valid_in  = req_accept || (in_valid_ff && !fire);
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_tready);

   // Result fields from the state after the item.
   assign rsp_data_in = {
      state_in.attempts,
      state_in.last_ok,
      (state_in.phase != bwds_pkg::PH_IDLE),
      (state_in.phase == bwds_pkg::PH_BURN2),
      (state_in.phase == bwds_pkg::PH_BURN1),
      ((state_in.phase == bwds_pkg::PH_BURN1) || (state_in.phase == bwds_pkg::PH_BURN2))
   };

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         state_ff.phase    <= bwds_pkg::PH_IDLE;
         state_ff.timer    <= '0;
         state_ff.attempts <= '0;
         state_ff.last_ok  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_op_ff    <= req_tuser;
         in_sense_ff <= req_tdata[0];
         in_skip_ff  <= req_tdata[1];
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= ended;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(bwds_pkg::RSP_TDATA_W - bwds_pkg::RSP_FIELDS_W){1'b0}}, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

[rtl/bwds_csr.sv]
// Configuration register file for the burn-wire deploy sequencer.
`default_nettype none

module bwds_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [bwds_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bwds_pkg::CSR_DATA_W-1:0]  csr_data,
   output bwds_pkg::cfg_type                     cfg
);

   bwds_pkg::cfg_type cfg_ff;
   bwds_pkg::cfg_type cfg_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;

   // Decode the register index; unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (bwds_pkg::csr_index_type'(csr_index))
            bwds_pkg::CSR_REALTIME_MODE: cfg_in.realtime_mode = csr_data[0];
            bwds_pkg::CSR_BURN_TICKS:    cfg_in.burn_ticks    = csr_data;
            bwds_pkg::CSR_REST_TICKS:    cfg_in.rest_ticks    = csr_data;
            bwds_pkg::CSR_RECHECK_TICKS: cfg_in.recheck_ticks = csr_data;
            bwds_pkg::CSR_MAX_TRIES:
               cfg_in.max_tries = csr_data[bwds_pkg::TRIES_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.realtime_mode <= 1'b1;
         cfg_ff.burn_ticks    <= bwds_pkg::RESET_BURN_TICKS;
         cfg_ff.rest_ticks    <= bwds_pkg::RESET_REST_TICKS;
         cfg_ff.recheck_ticks <= bwds_pkg::RESET_RECHECK_TICKS;
         cfg_ff.max_tries     <= bwds_pkg::RESET_MAX_TRIES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[rtl/bwds_step.sv]
// Next-state logic of the burn-wire deploy sequencer for one input item.
`default_nettype none

module bwds_step (
   input  wire bwds_pkg::cfg_type       cfg,
   input  wire bwds_pkg::seq_state_type cur,
   input  wire logic                    op,
   input  wire logic                    sense,
   input  wire logic                    skip,
   output bwds_pkg::seq_state_type      nxt,
   output logic                         ended
);

   logic [bwds_pkg::TICKS_W-1:0] burn_sel;
   logic [bwds_pkg::TICKS_W-1:0] rest_sel;
   logic [bwds_pkg::TICKS_W-1:0] recheck_sel;
   logic [bwds_pkg::TIMER_W-1:0] burn_len;
   logic [bwds_pkg::TIMER_W-1:0] phase_len;
   logic [bwds_pkg::TIMER_W-1:0] timer_inc;
   logic [bwds_pkg::TRIES_W-1:0] try_limit;
   logic                         rest_zero;
   logic                         recheck_zero;
   logic                         phase_done;
   logic                         tries_spent;

   // Durations for the selected mode.
   assign burn_sel    = cfg.realtime_mode ? cfg.burn_ticks    : bwds_pkg::DEBUG_BURN_TICKS;
   assign rest_sel    = cfg.realtime_mode ? cfg.rest_ticks    : bwds_pkg::DEBUG_REST_TICKS;
   assign recheck_sel = cfg.realtime_mode ? cfg.recheck_ticks : bwds_pkg::DEBUG_RECHECK_TICKS;

   // A burn lasts twice the burn setting, and at least one tick.
   assign burn_len     = (burn_sel == '0) ? bwds_pkg::TIMER_W'(1) : {burn_sel, 1'b0};
   assign rest_zero    = (rest_sel == '0);
   assign recheck_zero = (recheck_sel == '0);

   // Length of the current phase.
   always_comb begin
      unique case (cur.phase)
         bwds_pkg::PH_BURN1, bwds_pkg::PH_BURN2: phase_len = burn_len;
         bwds_pkg::PH_REST1, bwds_pkg::PH_REST2: phase_len = {1'b0, rest_sel};
         bwds_pkg::PH_RECHECK:                   phase_len = {1'b0, recheck_sel};
         default:                                phase_len = '0;
      endcase
   end

   // Timer advance and end-of-phase test.
   assign timer_inc  = cur.timer + bwds_pkg::TIMER_W'(1);
   assign phase_done = (timer_inc >= phase_len);

   // A zero try limit behaves as one attempt.
   assign try_limit   = (cfg.max_tries == '0) ? bwds_pkg::TRIES_W'(1) : cfg.max_tries;
   assign tries_spent = (cur.attempts >= try_limit);

   // Phase update; zero-length rests and rechecks are passed through at once.
   always_comb begin
      logic rest2_end;
      logic recheck_end;
      logic do_retry;
      logic do_ok;

      nxt         = cur;
      ended       = 1'b0;
      rest2_end   = 1'b0;
      recheck_end = 1'b0;
      do_retry    = 1'b0;
      do_ok       = 1'b0;

      if (op == bwds_pkg::OP_START) begin
         if (cur.phase == bwds_pkg::PH_IDLE) begin
            nxt.timer = '0;
            if (skip) begin
               nxt.attempts = '0;
               nxt.last_ok  = 1'b1;
               ended        = 1'b1;
            end else begin
               nxt.attempts = bwds_pkg::TRIES_W'(1);
               nxt.phase    = bwds_pkg::PH_BURN1;
            end
         end
      end else if (cur.phase != bwds_pkg::PH_IDLE) begin
         if (!phase_done) begin
            nxt.timer = timer_inc;
         end else begin
            nxt.timer = '0;
            unique case (cur.phase)
               bwds_pkg::PH_BURN1:
                  nxt.phase = rest_zero ? bwds_pkg::PH_BURN2 : bwds_pkg::PH_REST1;
               bwds_pkg::PH_REST1: nxt.phase = bwds_pkg::PH_BURN2;
               bwds_pkg::PH_BURN2: begin
                  if (rest_zero) begin
                     rest2_end = 1'b1;
                  end else begin
                     nxt.phase = bwds_pkg::PH_REST2;
                  end
               end
               bwds_pkg::PH_REST2:   rest2_end   = 1'b1;
               bwds_pkg::PH_RECHECK: recheck_end = 1'b1;
               default:              nxt.phase   = bwds_pkg::PH_IDLE;
            endcase

            // Sense sample after the second rest.
            if (rest2_end) begin
               if (sense) begin
                  do_retry = 1'b1;
               end else if (recheck_zero) begin
                  do_ok = 1'b1;
               end else begin
                  nxt.phase = bwds_pkg::PH_RECHECK;
               end
            end

            // Confirming sample after the recheck wait.
            if (recheck_end) begin
               do_retry = sense;
               do_ok    = !sense;
            end

            if (do_ok) begin
               nxt.phase   = bwds_pkg::PH_IDLE;
               nxt.last_ok = 1'b1;
               ended       = 1'b1;
            end

            // Next attempt, or failure when the tries are used up.
            if (do_retry) begin
               if (tries_spent) begin
                  nxt.phase   = bwds_pkg::PH_IDLE;
                  nxt.last_ok = 1'b0;
                  ended       = 1'b1;
               end else begin
                  nxt.attempts = cur.attempts + bwds_pkg::TRIES_W'(1);
                  nxt.phase    = bwds_pkg::PH_BURN1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

[rtl/bwds_checker.sv]
// Port-level checks on the burn-wire deploy sequencer's result channel, bound to the top level.
`default_nettype none

module bwds_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [bwds_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                             rsp_tlast
);

   // A stalled result transaction holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // The two elements never burn together.
   a_one_element: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[1] && rsp_tdata[2]))
      else $error("both burn elements on");

   // The shared supply is on exactly while one element burns.
   a_common_switch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[1] || rsp_tdata[2])))
      else $error("shared supply out of step with elements");

   // A run that finishes leaves the block idle.
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !rsp_tdata[3] && !rsp_tdata[0])
      else $error("finished run still busy");

endmodule

bind burn_wire_deploy_sequencer bwds_checker u_bwds_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
